// ----- rtl/nfr_pkg.sv -----
// ----------------------------------------------------------------------------
// nfr_pkg
// Shared types and constants for the nadir frame rotation pipeline.
// ----------------------------------------------------------------------------
package nfr_pkg;

    // square root: one result bit per stage, 64-bit radicand
    localparam int NFR_SQ_STEPS = 32;
    // divider: one quotient bit per stage, quotient never exceeds 2^30
    localparam int NFR_DV_STEPS = 31;
    // normalizer depth: 5 prep stages, sum, root, round, divide setup, divide, sign
    localparam int NFR_UNIT_LAT = 6 + NFR_SQ_STEPS + 2 + NFR_DV_STEPS + 1;

    localparam logic [63:0] NFR_HALF_LSB = 64'd1 << 29;
    localparam logic [33:0] NFR_ONE_Q30  = 34'd1 << 30;

    typedef struct packed {
        logic vld;
        logic zero;   // input vector was all zero
    } t_nfr_ctl;

endpackage

// ----- rtl/nfr_unit.sv -----
// ----------------------------------------------------------------------------
// nfr_unit
// Pipelined normalizer: three signed 64-bit components in, Q2.30 unit
// vector out. Block exponent shift, sum of squares, rounded square root,
// then a bit-per-stage divider for each component.
// ----------------------------------------------------------------------------
module nfr_unit
    import nfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_nfr_ctl         i_ctl,
    input  logic [2:0][63:0] i_w,
    output t_nfr_ctl         o_ctl,
    output logic [2:0][31:0] o_u
);

    t_nfr_ctl r_ctl [0:NFR_UNIT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NFR_UNIT_LAT; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < NFR_UNIT_LAT; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    assign o_ctl = r_ctl[NFR_UNIT_LAT-1];

    // ---- stage 1: magnitudes and their OR (leading one of OR = of max)
    logic [63:0] r_m1 [0:2];
    logic [2:0]  r_s1;
    logic [63:0] r_or1;
    logic [63:0] n_m1 [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m1[i] = i_w[i][63] ? (64'd0 - i_w[i]) : i_w[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m1[i] <= n_m1[i];
                r_s1[i] <= i_w[i][63];
            end
            r_or1 <= n_m1[0] | n_m1[1] | n_m1[2];
        end
    end

    // ---- stage 2: per-byte leading one
    logic [63:0] r_m2 [0:2];
    logic [2:0]  r_s2;
    logic [7:0]  r_gnz2;
    logic [2:0]  r_gpos2 [0:7];
    logic [7:0]  n_gnz2;
    logic [2:0]  n_gpos2 [0:7];

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            n_gnz2[g]  = |r_or1[8*g +: 8];
            n_gpos2[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (r_or1[8*g + b]) begin
                    n_gpos2[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2   <= r_m1;
            r_s2   <= r_s1;
            r_gnz2 <= n_gnz2;
            r_gpos2 <= n_gpos2;
        end
    end

    // ---- stage 3: leading one position of the word
    logic [63:0] r_m3 [0:2];
    logic [2:0]  r_s3;
    logic [5:0]  r_lead3;
    logic [5:0]  n_lead3;

    always_comb begin
        n_lead3 = 6'd0;
        for (int g = 0; g < 8; g++) begin
            if (r_gnz2[g]) begin
                n_lead3 = {3'(g), r_gpos2[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m3    <= r_m2;
            r_s3    <= r_s2;
            r_lead3 <= n_lead3;
        end
    end

    // ---- stage 4: shift so the largest magnitude sits in [2^30, 2^31)
    logic [30:0] r_m4 [0:2];
    logic [2:0]  r_s4;
    logic [30:0] n_m4 [0:2];
    logic [63:0] w_sh [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_lead3 > 6'd30) begin
                w_sh[i] = r_m3[i] >> (r_lead3 - 6'd30);
            end else begin
                w_sh[i] = r_m3[i] << (6'd30 - r_lead3);
            end
            n_m4[i] = w_sh[i][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m4 <= n_m4;
            r_s4 <= r_s3;
        end
    end

    // ---- stage 5: squares
    logic [61:0] r_sqr5 [0:2];
    logic [30:0] r_m5 [0:2];
    logic [2:0]  r_s5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sqr5[i] <= r_m4[i] * r_m4[i];
            end
            r_m5 <= r_m4;
            r_s5 <= r_s4;
        end
    end

    // ---- square root: stage 6 loads the sum, then one bit per stage
    logic [63:0] r_sq_s  [0:NFR_SQ_STEPS];
    logic [63:0] r_sq_r  [0:NFR_SQ_STEPS];
    logic [30:0] r_sq_m  [0:NFR_SQ_STEPS][0:2];
    logic [2:0]  r_sq_sg [0:NFR_SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_s[0]  <= 64'(r_sqr5[0]) + 64'(r_sqr5[1]) + 64'(r_sqr5[2]);
            r_sq_r[0]  <= 64'd0;
            r_sq_m[0]  <= r_m5;
            r_sq_sg[0] <= r_s5;
        end
    end

    for (genvar k = 0; k < NFR_SQ_STEPS; k++) begin : g_sq
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
        logic [63:0] w_trial;

        assign w_trial = r_sq_r[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sq_s[k] >= w_trial) begin
                    r_sq_s[k+1] <= r_sq_s[k] - w_trial;
                    r_sq_r[k+1] <= (r_sq_r[k] >> 1) + BIT;
                end else begin
                    r_sq_s[k+1] <= r_sq_s[k];
                    r_sq_r[k+1] <= r_sq_r[k] >> 1;
                end
                r_sq_m[k+1]  <= r_sq_m[k];
                r_sq_sg[k+1] <= r_sq_sg[k];
            end
        end
    end

    // ---- round the root, halves up
    logic [32:0] r_n;
    logic [30:0] r_rm [0:2];
    logic [2:0]  r_rs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n  <= r_sq_r[NFR_SQ_STEPS][32:0]
                    + 33'(r_sq_s[NFR_SQ_STEPS] > r_sq_r[NFR_SQ_STEPS]);
            r_rm <= r_sq_m[NFR_SQ_STEPS];
            r_rs <= r_sq_sg[NFR_SQ_STEPS];
        end
    end

    // ---- divider setup: numerator (m << 30) + n/2, top bits preloaded
    logic [32:0] r_dv_rem [0:NFR_DV_STEPS][0:2];
    logic [30:0] r_dv_lo  [0:NFR_DV_STEPS][0:2];
    logic [30:0] r_dv_q   [0:NFR_DV_STEPS][0:2];
    logic [32:0] r_dv_n   [0:NFR_DV_STEPS];
    logic [2:0]  r_dv_sg  [0:NFR_DV_STEPS];
    logic [61:0] w_num [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {1'b0, r_rm[i], 30'd0} + 62'(r_n >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= {2'd0, w_num[i][61:31]};
                r_dv_lo[0][i]  <= w_num[i][30:0];
                r_dv_q[0][i]   <= 31'd0;
            end
            r_dv_n[0]  <= r_n;
            r_dv_sg[0] <= r_rs;
        end
    end

    for (genvar j = 0; j < NFR_DV_STEPS; j++) begin : g_dv
        logic [33:0] w_t [0:2];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_t[i] = {r_dv_rem[j][i], r_dv_lo[j][i][30]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_t[i] >= {1'b0, r_dv_n[j]}) begin
                        r_dv_rem[j+1][i] <= 33'(w_t[i] - {1'b0, r_dv_n[j]});
                        r_dv_q[j+1][i]   <= {r_dv_q[j][i][29:0], 1'b1};
                    end else begin
                        r_dv_rem[j+1][i] <= w_t[i][32:0];
                        r_dv_q[j+1][i]   <= {r_dv_q[j][i][29:0], 1'b0};
                    end
                    r_dv_lo[j+1][i] <= {r_dv_lo[j][i][29:0], 1'b0};
                end
                r_dv_n[j+1]  <= r_dv_n[j];
                r_dv_sg[j+1] <= r_dv_sg[j];
            end
        end
    end

    // ---- apply signs
    logic [2:0][31:0] r_u;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= r_dv_sg[NFR_DV_STEPS][i] ? (32'd0 - 32'(r_dv_q[NFR_DV_STEPS][i]))
                                                   : 32'(r_dv_q[NFR_DV_STEPS][i]);
            end
        end
    end

    assign o_u = r_u;

endmodule

// ----- rtl/nadir_frame_rotation.sv -----
// ----------------------------------------------------------------------------
// nadir_frame_rotation
// Rotation into the nadir-pointing frame from one position/velocity sample.
// ----------------------------------------------------------------------------
// One request is accepted per clock while the pipeline is not held.
// The depth is set by the two normalizers running side by side, each with a
// 32-stage square root and a 31-stage divider; cross products and the final
// y axis add five stages. The whole pipeline holds when the output register
// is full and not taken. Rows are x, y, z in Q2.30; tuser flags a zero
// position or a velocity parallel to it, with the matrix then all zero.
module nadir_frame_rotation
    import nfr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each, from bit 0 up)
    input  logic [191:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each, from bit 0 up)
    output logic [287:0] o_m_axis_tdata,
    // degenerate
    output logic [0:0]   o_m_axis_tuser
);

    logic w_en;
    logic r_ovld;

    assign w_en            = ~r_ovld | i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---- stage 1: cross-product terms
    logic signed [31:0] w_p [0:2];
    logic signed [31:0] w_v [0:2];
    logic signed [63:0] r_pr1 [0:5];
    logic signed [31:0] r_p1 [0:2];
    logic               r_v1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p[i] = i_s_axis_tdata[32*i +: 32];
            w_v[i] = i_s_axis_tdata[96 + 32*i +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pr1[0] <= w_p[1] * w_v[2];
            r_pr1[1] <= w_p[2] * w_v[1];
            r_pr1[2] <= w_p[2] * w_v[0];
            r_pr1[3] <= w_p[0] * w_v[2];
            r_pr1[4] <= w_p[0] * w_v[1];
            r_pr1[5] <= w_p[1] * w_v[0];
            r_p1     <= w_p;
        end
    end

    // ---- stage 2: p x v and -p
    logic [2:0][63:0] r_c2;
    logic [2:0][63:0] r_nz2;
    logic             r_v2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_c2[i]  <= r_pr1[2*i] - r_pr1[2*i+1];
                r_nz2[i] <= 64'sd0 - 64'(r_p1[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    // ---- normalizers
    t_nfr_ctl         w_xin;
    t_nfr_ctl         w_zin;
    t_nfr_ctl         w_xout;
    t_nfr_ctl         w_zout;
    logic [2:0][31:0] w_xa;
    logic [2:0][31:0] w_za;

    assign w_xin = '{vld: r_v2, zero: (r_c2 == '0)};
    assign w_zin = '{vld: r_v2, zero: (r_nz2 == '0)};

    nfr_unit u_unit_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_xin),
        .i_w     (r_c2),
        .o_ctl   (w_xout),
        .o_u     (w_xa)
    );

    nfr_unit u_unit_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_zin),
        .i_w     (r_nz2),
        .o_ctl   (w_zout),
        .o_u     (w_za)
    );

    // ---- y = z x x: products, differences, rescale
    logic signed [31:0] w_zs [0:2];
    logic signed [31:0] w_xs [0:2];
    logic signed [63:0] r_ypr [0:5];
    logic [2:0][31:0]   r_xa1, r_za1, r_xa2, r_za2;
    logic               r_vy1, r_vy2, r_dg1, r_dg2;
    logic signed [63:0] r_yd [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_zs[i] = w_za[i];
            w_xs[i] = w_xa[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ypr[0] <= w_zs[1] * w_xs[2];
            r_ypr[1] <= w_zs[2] * w_xs[1];
            r_ypr[2] <= w_zs[2] * w_xs[0];
            r_ypr[3] <= w_zs[0] * w_xs[2];
            r_ypr[4] <= w_zs[0] * w_xs[1];
            r_ypr[5] <= w_zs[1] * w_xs[0];
            r_xa1    <= w_xa;
            r_za1    <= w_za;
            r_dg1    <= w_xout.zero | w_zout.zero;
            for (int i = 0; i < 3; i++) begin
                r_yd[i] <= r_ypr[2*i] - r_ypr[2*i+1];
            end
            r_xa2 <= r_xa1;
            r_za2 <= r_za1;
            r_dg2 <= r_dg1;
        end
    end

    logic [63:0]      w_ymag [0:2];
    logic [33:0]      w_yq   [0:2];
    logic [2:0][31:0] w_ya;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ymag[i] = r_yd[i][63] ? (64'd0 - r_yd[i]) : r_yd[i];
            w_yq[i]   = 34'((w_ymag[i] + NFR_HALF_LSB) >> 30);
            if (w_yq[i] > NFR_ONE_Q30) begin
                w_yq[i] = NFR_ONE_Q30;
            end
            w_ya[i] = r_yd[i][63] ? (32'd0 - w_yq[i][31:0]) : w_yq[i][31:0];
        end
    end

    // ---- output register
    logic [287:0] r_odata;
    logic         r_odg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odg <= r_dg2;
            if (r_dg2) begin
                r_odata <= '0;
            end else begin
                r_odata <= {r_za2, w_ya, r_xa2};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vy1  <= 1'b0;
            r_vy2  <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vy1  <= w_xout.vld & w_zout.vld;
            r_vy2  <= r_vy1;
            r_ovld <= r_vy2;
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_odg;

endmodule

// ----- tb/sv/nadir_frame_rotation_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nadir_frame_rotation_test
// Drives position/velocity requests through the rotation pipeline and checks
// every matrix and degenerate flag against a directed table or a bit-exact predictor, with random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module nadir_frame_rotation_test;

    localparam int N_RANDOM    = 600;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 200;
    localparam logic signed [31:0] Q_ONE = 32'sd1073741824;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [31:0] m [9];
        logic               degen;
    } t_matrix;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic               has_exp;
        t_matrix            exp;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [191:0] s_data;
    logic         m_valid;
    logic         m_ready;
    logic [287:0] m_data;
    logic [0:0]   m_user;

    t_matrix expected_matrices [$];
    t_row    stim [$];
    int      n_errors;
    int      idle_cnt;
    bit      stim_done;
    bit      calm;

    nadir_frame_rotation i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mag(input logic signed [63:0] w);
        return w < 0 ? -w : w;
    endfunction

    // rounded integer square root, halves up
    function automatic logic [63:0] root_round(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s > r) r = r + 1;
        return r;
    endfunction

    task automatic unit_vec(input logic signed [63:0] w [3],
                            output logic signed [63:0] u [3]);
        logic [63:0] m [3];
        logic [63:0] big;
        logic [63:0] sum;
        logic [63:0] n;
        logic [63:0] q;
        big = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(w[i]);
            if (m[i] > big) big = m[i];
        end
        while (big >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            big = big >> 1;
        end
        while (big < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            big = big << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        n = root_round(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (n >> 1)) / n;
            u[i] = w[i] < 0 ? -$signed(q) : $signed(q);
        end
    endtask

    function automatic logic signed [63:0] rescale(input logic signed [63:0] d);
        logic [63:0] m;
        m = (mag(d) + (64'd1 << 29)) >> 30;
        if (m > 64'd1073741824) m = 64'd1073741824;
        return d < 0 ? -$signed(m) : $signed(m);
    endfunction

    task automatic predict_frame(input logic signed [31:0] p32 [3],
                                 input logic signed [31:0] v32 [3],
                                 output t_matrix r);
        logic signed [63:0] p [3];
        logic signed [63:0] v [3];
        logic signed [63:0] c [3];
        logic signed [63:0] nz [3];
        logic signed [63:0] xa [3];
        logic signed [63:0] za [3];
        logic signed [63:0] ya [3];
        for (int i = 0; i < 3; i++) begin
            p[i] = p32[i];
            v[i] = v32[i];
            nz[i] = -p[i];
        end
        c[0] = p[1] * v[2] - p[2] * v[1];
        c[1] = p[2] * v[0] - p[0] * v[2];
        c[2] = p[0] * v[1] - p[1] * v[0];
        for (int i = 0; i < 9; i++) r.m[i] = 0;
        r.degen = 1'b1;
        if ((p[0] == 0 && p[1] == 0 && p[2] == 0) ||
            (c[0] == 0 && c[1] == 0 && c[2] == 0)) return;
        unit_vec(nz, za);
        unit_vec(c, xa);
        ya[0] = rescale(za[1] * xa[2] - za[2] * xa[1]);
        ya[1] = rescale(za[2] * xa[0] - za[0] * xa[2]);
        ya[2] = rescale(za[0] * xa[1] - za[1] * xa[0]);
        for (int i = 0; i < 3; i++) begin
            r.m[i]     = xa[i][31:0];
            r.m[3 + i] = ya[i][31:0];
            r.m[6 + i] = za[i][31:0];
        end
        r.degen = 1'b0;
    endtask

    task automatic add_row(input logic signed [31:0] px, py, pz, vx, vy, vz);
        t_row r;
        r.p[0] = px; r.p[1] = py; r.p[2] = pz;
        r.v[0] = vx; r.v[1] = vy; r.v[2] = vz;
        r.has_exp = 1'b0;
        stim.push_back(r);
    endtask

    task automatic add_row_exp(input logic signed [31:0] px, py, pz, vx, vy, vz,
                               input t_matrix e);
        add_row(px, py, pz, vx, vy, vz);
        stim[$].has_exp = 1'b1;
        stim[$].exp = e;
    endtask

    function automatic logic signed [31:0] rnd_comp();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 6)) - 3;
            1: return $urandom_range(0, 1) ? S_MIN : S_MAX;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // directed table
    initial begin
        t_matrix e0, eid;
        for (int i = 0; i < 9; i++) begin
            e0.m[i] = 0;
            eid.m[i] = 0;
        end
        e0.degen = 1'b1;
        // p on -z, v on +x: x=(0,-1,0)... read off: p=(0,0,-1), v=(1,0,0)
        // p x v = (0,-1,0); z = (0,0,1); y = z x x = (1,0,0)
        eid.m[1] = -Q_ONE; eid.m[3] = Q_ONE; eid.m[8] = Q_ONE;
        eid.degen = 1'b0;
        add_row_exp(0, 0, 0, 0, 0, 0, e0);                   // all zero
        add_row_exp(0, 0, 0, 5, -7, 9, e0);                  // zero position
        add_row_exp(3, -4, 5, 0, 0, 0, e0);                  // zero velocity
        add_row_exp(2, -4, 6, -1, 2, -3, e0);                // velocity parallel
        add_row_exp(S_MAX, S_MAX, S_MAX, 1, 1, 1, e0);
        add_row_exp(0, 0, -1, 1, 0, 0, eid);
        add_row_exp(0, 0, S_MIN, S_MAX, 0, 0, eid);
        add_row(S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX);
        add_row(S_MAX, S_MIN, 1, -1, S_MAX, S_MIN);
        add_row(S_MIN, 0, 0, 0, S_MIN, 0);
        add_row(-1, -1, -1, -1, 1, 0);
        add_row(1, 0, 0, 0, 0, 1);
        add_row(S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX);
        add_row(7000000, -42, 1, 3, 900000, -5);
        add_row(-6378137, 0, 0, 0, -7500, 12);
        add_row(1, 2, 3, 4, 5, 6);
        add_row(32'sh5555_5555, 32'sh2aaa_aaaa, -1, 32'sh1234_5678, -2, 32'sh7654_3210);
    end

    // source
    initial begin
        t_row r;
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        int gap;
        int k;
        s_valid = 1'b0;
        s_data  = '0;
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        calm = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < 17 + N_RANDOM; n++) begin
            if (n < 17) begin
                r = stim[n];
            end else begin
                k = $urandom_range(0, 19);
                for (int i = 0; i < 3; i++) begin
                    r.p[i] = rnd_comp();
                    r.v[i] = rnd_comp();
                end
                if (k == 0) begin
                    // parallel velocity
                    for (int i = 0; i < 3; i++) begin
                        r.p[i] = $signed($urandom_range(0, 200)) - 100;
                        r.v[i] = -3 * r.p[i];
                    end
                end else if (k == 1) begin
                    for (int i = 0; i < 3; i++) r.p[i] = 0;
                end
                r.has_exp = 1'b0;
            end
            if (n > 17 + N_RANDOM - 80) calm = 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 14);
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            p = r.p;
            v = r.v;
            s_valid <= 1'b1;
            s_data  <= {r.v[2], r.v[1], r.v[0], r.p[2], r.p[1], r.p[0]};
            @(posedge i_clk);
            while (!s_ready) @(posedge i_clk);
            if (r.has_exp) begin
                expected_matrices.push_back(r.exp);
            end else begin
                t_matrix e;
                predict_frame(p, v, e);
                expected_matrices.push_back(e);
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // sink: random stalls plus one long hold-off early in the run
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        m_ready <= 1'b1;
        repeat (40) @(posedge i_clk);
        m_ready <= 1'b0;
        repeat (300) @(posedge i_clk);
        m_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 14);
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_ready <= 1'b1;
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_matrices.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_data, m_user);
                n_errors++;
            end else begin
                t_matrix e;
                e = expected_matrices.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (m_data[32*i +: 32] !== e.m[i]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                                 e.m[i], $signed(m_data[32*i +: 32]));
                        n_errors++;
                    end
                end
                if (m_user[0] !== e.degen) begin
                    $display("%0t: degenerate expected %b actual %b", $time, e.degen, m_user[0]);
                    n_errors++;
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        n_errors = 0;
        idle_cnt = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= WDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", WDOG_LIMIT);
                $display("nadir_frame_rotation_test: done, errors");
                $finish;
            end
            if (stim_done && expected_matrices.size() == 0) begin
                repeat (DRAIN_WAIT) @(posedge i_clk);
                if (n_errors == 0 && expected_matrices.size() == 0)
                    $display("nadir_frame_rotation_test: done, clean");
                else
                    $display("nadir_frame_rotation_test: done, errors");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
rtl/nfr_pkg.sv
rtl/nfr_unit.sv
rtl/nadir_frame_rotation.sv
tb/sv/nadir_frame_rotation_test.sv
